// ----- sv/dep_pkg.sv -----
// Package for the directory entry parser: result kinds, result record type,
// header byte positions and configuration register indexes. No dependencies.

package dep_pkg;

  localparam int OFFSET_BITS_DEF = 12;
  localparam int CNT_W = 13;
  localparam int RLEN_W = 16;
  localparam int BS_W = 17;
  localparam int MAX_LOG_BS = 2;

  localparam logic [CNT_W-1:0] POS_RLEN_LO = 13'd4;
  localparam logic [CNT_W-1:0] POS_RLEN_HI = 13'd5;
  localparam logic [CNT_W-1:0] POS_NAME_LEN = 13'd6;
  localparam logic [CNT_W-1:0] POS_TYPE = 13'd7;
  localparam logic [CNT_W-1:0] HDR_LEN = 13'd8;
  localparam logic [CNT_W-1:0] POS_NAME_2ND = 13'd9;

  localparam logic [7:0] DOT = 8'h2E;
  localparam logic [1:0] ALIGN_MASK = 2'b11;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_BLOCK_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILETYPE = 1'b1;

  typedef enum logic [1:0] {
    KIND_NAME    = 2'd0,
    KIND_ENTRY   = 2'd1,
    KIND_CORRUPT = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  name_byte;
    logic [31:0] inode;
    logic [7:0]  ftype;
    logic [7:0]  name_count;
    logic        last;
  } result_t;

endpackage

// ----- sv/directory_entry_parser.sv -----
// Directory entry parser: walks variable-length directory records
// from a byte stream and emits name bytes, entry records and corruption.
// Depends on dep_pkg.
//
// Flow: an item is held in the input register; its results enter the two-slot
// result queue when the item is processed and leave from the queue head.
// Throughput: one byte per cycle unless the queue stays full; a byte with two
// results also stalls while the queue holds an earlier result after any pop.
// Reset: synchronous active-low rst_n clears configuration, parse state and
// queue; a corrupt record freezes the parser until the next reset.

module directory_entry_parser #(
  parameter int OFFSET_BITS = dep_pkg::OFFSET_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dep_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [1:0]                    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_data_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_kind,
  output logic [7:0]                    out_name_byte,
  output logic [31:0]                   out_entry_inode,
  output logic [7:0]                    out_entry_type,
  output logic [7:0]                    out_entry_name_len,
  output logic                          out_last
);
  import dep_pkg::*;

  localparam logic [1:0] MAX_LOG =
    ((OFFSET_BITS - 10) < MAX_LOG_BS) ? 2'(OFFSET_BITS - 10) : 2'(MAX_LOG_BS);

  logic [1:0]             lbs_r;
  logic                   ft_r;
  logic                   st_v_r;
  logic [7:0]             st_b_r;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [OFFSET_BITS-1:0] rs_r, rs_nxt;
  logic [CNT_W-1:0]       rc_r, rc_nxt;
  logic [RLEN_W-1:0]      rl_r, rl_nxt;
  logic [7:0]             nl_r, nl_nxt;
  logic [31:0]            ino_r, ino_nxt;
  logic [7:0]             typ_r, typ_nxt;
  logic                   held_r, held_nxt;
  logic                   skip_r, skip_nxt;
  logic                   bad_r, bad_nxt;
  result_t                q0_r, q1_r, q0_nxt, q1_nxt;
  logic [1:0]             q_cnt_r, q_cnt_nxt;

  logic [1:0]             log_eff;
  logic [BS_W-1:0]        bs;
  logic [BS_W-1:0]        bs_mask;
  logic [7:0]             b;
  logic [1:0]             nn;
  logic                   ev;
  logic                   bad_ev;
  result_t                nm0, nm1, ent, r0, r1;
  logic [1:0]             n;
  logic                   pop;
  logic [1:0]             cnt_p;
  result_t                a0;
  logic                   room;
  logic                   proc;

  assign cfg_ready = 1'b1;
  assign b = st_b_r;

  always_comb begin
    log_eff = (lbs_r > MAX_LOG) ? MAX_LOG : lbs_r;
    bs = BS_W'(1024) << log_eff;
    bs_mask = bs - BS_W'(1);
  end

  always_comb begin
    off_nxt = off_r;
    rs_nxt = rs_r;
    rc_nxt = rc_r;
    rl_nxt = rl_r;
    nl_nxt = nl_r;
    ino_nxt = ino_r;
    typ_nxt = typ_r;
    held_nxt = held_r;
    skip_nxt = skip_r;
    bad_nxt = bad_r;
    nn = 2'd0;
    nm0 = '0;
    nm1 = '0;
    ent = '0;
    ev = 1'b0;
    bad_ev = 1'b0;
    if (!bad_r) begin
      if (rc_r == '0) begin
        rs_nxt = off_r;
      end
      if (rc_r < POS_RLEN_LO) begin
        case (rc_r[1:0])
          2'd0: ino_nxt = {24'b0, b};
          2'd1: ino_nxt[15:8] = b;
          2'd2: ino_nxt[23:16] = b;
          2'd3: ino_nxt[31:24] = b;
          default: ino_nxt = ino_r;
        endcase
      end else if (rc_r == POS_RLEN_LO) begin
        rl_nxt = {8'b0, b};
      end else if (rc_r == POS_RLEN_HI) begin
        rl_nxt[15:8] = b;
      end else if (rc_r == POS_NAME_LEN) begin
        nl_nxt = b;
        skip_nxt = (ino_r == '0);
        if ((rl_r < (RLEN_W'(b) + RLEN_W'(HDR_LEN))) || ((rl_r[1:0] & ALIGN_MASK) != 2'b0) ||
            ((BS_W'(rs_r) + BS_W'(rl_r)) > bs)) begin
          bad_ev = 1'b1;
          bad_nxt = 1'b1;
        end
      end else if (rc_r == POS_TYPE) begin
        typ_nxt = b;
      end else if ((rc_r < (CNT_W'(nl_r) + HDR_LEN)) && !skip_r) begin
        nm0.kind = KIND_NAME;
        nm1.kind = KIND_NAME;
        if (rc_r == HDR_LEN) begin
          held_nxt = 1'b0;
          if (nl_r == 8'd1 && b == DOT) begin
            skip_nxt = 1'b1;
          end else if (nl_r == 8'd2 && b == DOT) begin
            held_nxt = 1'b1;
          end else begin
            nm0.name_byte = b;
            nn = 2'd1;
          end
        end else if (rc_r == POS_NAME_2ND && nl_r == 8'd2 && held_r) begin
          if (b == DOT) begin
            skip_nxt = 1'b1;
          end else begin
            nm0.name_byte = DOT;
            nm1.name_byte = b;
            nn = 2'd2;
          end
        end else begin
          nm0.name_byte = b;
          nn = 2'd1;
        end
      end
      if (!bad_ev) begin
        if ((rc_r >= POS_TYPE) && ((RLEN_W'(rc_r) + RLEN_W'(1)) == rl_r)) begin
          ev = !skip_nxt;
          rc_nxt = '0;
        end else begin
          rc_nxt = rc_r + CNT_W'(1);
        end
        off_nxt = (off_r + OFFSET_BITS'(1)) & bs_mask[OFFSET_BITS-1:0];
      end
    end
    ent.kind = KIND_ENTRY;
    ent.inode = ino_nxt;
    ent.ftype = ft_r ? typ_nxt : 8'd0;
    ent.name_count = nl_nxt;
  end

  always_comb begin
    r0 = '0;
    r1 = '0;
    n = 2'd0;
    if (bad_ev) begin
      r0.kind = KIND_CORRUPT;
      r0.last = 1'b1;
      n = 2'd1;
    end else begin
      r0 = (nn != 2'd0) ? nm0 : ent;
      r1 = (nn == 2'd2) ? nm1 : ent;
      n = (nn + {1'b0, ev} > 2'd2) ? 2'd2 : nn + {1'b0, ev};
      if (n == 2'd2) begin
        r1.last = 1'b1;
      end else if (n == 2'd1) begin
        r0.last = 1'b1;
      end
    end
  end

  always_comb begin
    pop = (q_cnt_r != 2'd0) && out_ready;
    cnt_p = q_cnt_r - {1'b0, pop};
    a0 = pop ? q1_r : q0_r;
    room = (cnt_p == 2'd0) || (cnt_p == 2'd1 && n != 2'd2);
    proc = st_v_r && room;
    q0_nxt = (cnt_p == 2'd0) ? r0 : a0;
    q1_nxt = (cnt_p == 2'd0) ? r1 : (cnt_p == 2'd1) ? r0 : q1_r;
    q_cnt_nxt = cnt_p + (proc ? n : 2'd0);
  end

  assign in_ready = !st_v_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lbs_r <= '0;
      ft_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LOG_BLOCK_SIZE: lbs_r <= cfg_data;
        CFG_FILETYPE: ft_r <= cfg_data[0];
        default: lbs_r <= lbs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      st_b_r <= in_data_byte;
    end
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r <= 1'b0;
      q_cnt_r <= '0;
      off_r <= '0;
      rs_r <= '0;
      rc_r <= '0;
      rl_r <= '0;
      nl_r <= '0;
      ino_r <= '0;
      typ_r <= '0;
      held_r <= 1'b0;
      skip_r <= 1'b0;
      bad_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        st_v_r <= 1'b1;
      end else if (proc) begin
        st_v_r <= 1'b0;
      end
      q_cnt_r <= q_cnt_nxt;
      if (proc) begin
        off_r <= off_nxt;
        rs_r <= rs_nxt;
        rc_r <= rc_nxt;
        rl_r <= rl_nxt;
        nl_r <= nl_nxt;
        ino_r <= ino_nxt;
        typ_r <= typ_nxt;
        held_r <= held_nxt;
        skip_r <= skip_nxt;
        bad_r <= bad_nxt;
      end
    end
  end

  assign out_valid = (q_cnt_r != 2'd0);
  assign out_kind = q0_r.kind;
  assign out_name_byte = q0_r.name_byte;
  assign out_entry_inode = q0_r.inode;
  assign out_entry_type = q0_r.ftype;
  assign out_entry_name_len = q0_r.name_count;
  assign out_last = q0_r.last;

`ifndef SYNTH
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r != 2'd3) else $error("result queue overflow");

  a_corrupt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    bad_r |=> bad_r) else $error("corrupt flag cleared without reset");

  a_pair_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && n == 2'd2) |-> (cnt_p == 2'd0)) else $error("two results pushed without room");

  a_corrupt_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_CORRUPT) |-> out_last)
    else $error("corrupt result not marked last");

  a_frozen_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && bad_r) |-> (n == 2'd0)) else $error("result after corrupt record");
`endif

endmodule

// ----- sim/tb_top.sv -----
// Testbench for directory_entry_parser: streams directory entry bytes, predicts
// name, entry and corrupt results in its own parse model, and checks each one.
// Depends on dep_pkg and directory_entry_parser.

module tb_top;
  import dep_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MIN_RECORD = 12;
  localparam int OFF_W = OFFSET_BITS_DEF;

  typedef logic [7:0] name_q_t[$];

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [1:0]           cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_data_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           out_kind;
  logic [7:0]           out_name_byte;
  logic [31:0]          out_entry_inode;
  logic [7:0]           out_entry_type;
  logic [7:0]           out_entry_name_len;
  logic                 out_last;

  logic [OFF_W-1:0] blk_off = '0;
  logic [OFF_W-1:0] rec_start = '0;
  logic [CNT_W-1:0] rec_pos = '0;
  logic [15:0]      rec_len = '0;
  logic [7:0]       nm_len = '0;
  logic [31:0]      ino_acc = '0;
  logic [7:0]       typ_byte = '0;
  logic [7:0]       held_dot = '0;
  logic             skip_rec = 1'b0;
  logic             frozen = 1'b0;
  logic [1:0]       cfg_log = '0;
  logic             cfg_ft = 1'b0;

  result_t dir_results[$];
  result_t want;

  int src_gap_pct = 33;
  int sink_stall_pct = 70;
  int bytes_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int cycle_count = 0;

  directory_entry_parser u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_name_byte     (out_name_byte),
    .out_entry_inode   (out_entry_inode),
    .out_entry_type    (out_entry_type),
    .out_entry_name_len(out_entry_name_len),
    .out_last          (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(negedge clk) out_ready <= ($urandom_range(99) >= sink_stall_pct);

  function automatic int unsigned block_size_now();
    int unsigned lg;
    lg = 32'(cfg_log);
    if (lg > MAX_LOG_BS) lg = MAX_LOG_BS;
    if (lg > OFF_W - 10) lg = OFF_W - 10;
    return 1024 << lg;
  endfunction

  function automatic result_t name_result(input logic [7:0] b);
    result_t r;
    r = '0;
    r.kind = KIND_NAME;
    r.name_byte = b;
    return r;
  endfunction

  task automatic predict_dir_byte(input logic [7:0] b);
    result_t found[2];
    result_t r;
    int n;
    int unsigned bsz;
    int unsigned pos;
    n = 0;
    bsz = block_size_now();
    pos = 32'(rec_pos);
    if (frozen) return;
    if (pos == 0) rec_start = blk_off;
    if (pos < POS_RLEN_LO) begin
      if (pos == 0) ino_acc = {24'd0, b};
      else ino_acc[8*pos +: 8] = b;
    end else if (pos == POS_RLEN_LO) begin
      rec_len = {8'd0, b};
    end else if (pos == POS_RLEN_HI) begin
      rec_len[15:8] = b;
    end else if (pos == POS_NAME_LEN) begin
      nm_len = b;
      skip_rec = (ino_acc == 0);
      if (rec_len < HDR_LEN + nm_len || (rec_len[1:0] & ALIGN_MASK) != 0 ||
          rec_start + rec_len > bsz) begin
        r = '0;
        r.kind = KIND_CORRUPT;
        r.last = 1'b1;
        dir_results.push_back(r);
        frozen = 1'b1;
        return;
      end
    end else if (pos == POS_TYPE) begin
      typ_byte = b;
    end else if (pos < HDR_LEN + nm_len && !skip_rec) begin
      if (pos == HDR_LEN) begin
        held_dot = 8'h00;
        if (nm_len == 1 && b == DOT) begin
          skip_rec = 1'b1;
        end else if (nm_len == 2 && b == DOT) begin
          held_dot = b;
        end else begin
          found[n] = name_result(b);
          n++;
        end
      end else if (pos == POS_NAME_2ND && nm_len == 2 && held_dot == DOT) begin
        if (b == DOT) begin
          skip_rec = 1'b1;
        end else begin
          found[0] = name_result(held_dot);
          found[1] = name_result(b);
          n = 2;
        end
      end else begin
        found[n] = name_result(b);
        n++;
      end
    end
    if (pos >= POS_TYPE && pos + 1 == rec_len) begin
      if (!skip_rec) begin
        r = '0;
        r.kind = KIND_ENTRY;
        r.inode = ino_acc;
        r.ftype = cfg_ft ? typ_byte : 8'h00;
        r.name_count = nm_len;
        found[n] = r;
        n++;
      end
      rec_pos = '0;
    end else begin
      rec_pos = CNT_W'(pos + 1);
    end
    blk_off = OFF_W'((32'(blk_off) + 1) & (bsz - 1));
    for (int i = 0; i < n; i++) begin
      r = found[i];
      r.last = (i == n - 1);
      dir_results.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want_val);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch on %s at result %0d: got %0h, wanted %0h",
               what, results_checked, got, want_val);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (dir_results.size() == 0) begin
        report_mismatch("unrequested result kind", {30'd0, out_kind}, 32'd0);
      end else begin
        want = dir_results.pop_front();
        results_checked++;
        if (out_kind !== want.kind)
          report_mismatch("kind", 32'(out_kind), 32'(want.kind));
        if (out_name_byte !== want.name_byte)
          report_mismatch("name_byte", 32'(out_name_byte), 32'(want.name_byte));
        if (out_entry_inode !== want.inode)
          report_mismatch("entry_inode", out_entry_inode, want.inode);
        if (out_entry_type !== want.ftype)
          report_mismatch("entry_type", 32'(out_entry_type), 32'(want.ftype));
        if (out_entry_name_len !== want.name_count)
          report_mismatch("entry_name_len", 32'(out_entry_name_len), 32'(want.name_count));
        if (out_last !== want.last)
          report_mismatch("last", 32'(out_last), 32'(want.last));
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_dir_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_entry(input logic [31:0] ino, input logic [15:0] rlen,
                            input logic [7:0] ftype, input name_q_t nm);
    for (int i = 0; i < 4; i++) send_byte(ino[8*i +: 8]);
    send_byte(rlen[7:0]);
    send_byte(rlen[15:8]);
    send_byte(8'(nm.size()));
    send_byte(ftype);
    foreach (nm[i]) send_byte(nm[i]);
    for (int i = HDR_LEN + nm.size(); i < rlen; i++) send_byte(8'($urandom_range(255)));
  endtask

  task automatic settle_results();
    in_valid <= 1'b0;
    while (dir_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure(input logic [1:0] log_bs, input logic ft_on);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_LOG_BLOCK_SIZE;
    cfg_data <= log_bs;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_log = log_bs;
    @(negedge clk);
    cfg_index <= CFG_FILETYPE;
    cfg_data <= {1'($urandom_range(1)), ft_on};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_ft = ft_on;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_entry();
    name_q_t nm;
    int unsigned space;
    int unsigned rlen;
    int unsigned len;
    int unsigned pick;
    logic [31:0] ino;
    nm = {};
    len = 0;
    space = block_size_now() - blk_off;
    pick = $urandom_range(99);
    if (pick < 12) begin
      nm.push_back(DOT);
    end else if (pick < 24) begin
      nm.push_back(DOT);
      nm.push_back(DOT);
    end else if (pick < 40) begin
      nm.push_back(DOT);
      nm.push_back(($urandom_range(2) == 0) ? DOT : 8'($urandom_range(255)));
    end else if (pick < 44) begin
      len = $urandom_range(100, 255);
    end else if (pick >= 48) begin
      len = $urandom_range(1, 12);
    end
    for (int i = 0; i < len; i++)
      nm.push_back(($urandom_range(5) == 0) ? DOT : 8'($urandom_range(255)));
    while (nm.size() > space - HDR_LEN) void'(nm.pop_back());
    pick = $urandom_range(9);
    ino = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF : 32'($urandom);
    rlen = ((HDR_LEN + nm.size() + 3) / 4) * 4;
    if ($urandom_range(3) == 0) rlen += 4 * $urandom_range(1, 3);
    if (rlen > space || space - rlen < MIN_RECORD) rlen = space;
    send_entry(ino, 16'(rlen), 8'($urandom_range(255)), nm);
  endtask

  task automatic test_special_names();
    name_q_t nm;
    configure(2'd0, 1'b1);
    nm = {8'hFF};
    send_entry(32'hFFFF_FFFF, 16'd12, 8'hFF, nm);
    nm = {DOT};
    send_entry(32'd2, 16'd12, 8'd2, nm);
    nm = {DOT, DOT};
    send_entry(32'd2, 16'd12, 8'd2, nm);
    nm = {DOT, 8'h00};
    send_entry(32'd11, 16'd12, 8'd1, nm);
    nm = {8'h61, DOT};
    send_entry(32'h0000_0100, 16'd12, 8'd1, nm);
    nm = {8'h7A, 8'h7A};
    send_entry(32'd0, 16'd12, 8'd1, nm);
    nm = {};
    send_entry(32'h8000_0000, 16'd8, 8'h00, nm);
    nm = {DOT, DOT, DOT};
    send_entry(32'd5, 16'd16, 8'd7, nm);
  endtask

  // switch block size between records, mid-block; longest name
  task automatic test_block_size_change();
    name_q_t nm;
    settle_results();
    configure(2'd1, 1'b0);
    nm = {};
    for (int i = 0; i < 255; i++) nm.push_back(8'($urandom_range(255)));
    send_entry(32'($urandom), 16'd264, 8'($urandom_range(255)), nm);
    nm = {8'h41, 8'h42, 8'h43};
    send_entry(32'd77, 16'd12, 8'd2, nm);
  endtask

  task automatic test_random_traffic(input int target, input logic [1:0] log_bs,
                                     input logic ft_on, input int gap_pct,
                                     input int stall_pct);
    int start;
    settle_results();
    configure(log_bs, ft_on);
    src_gap_pct = gap_pct;
    sink_stall_pct = stall_pct;
    start = bytes_sent;
    while (bytes_sent - start < target) send_random_entry();
  endtask

  // record runs past the block end; parser must freeze afterwards
  task automatic test_corrupt_freeze();
    logic [15:0] rl;
    settle_results();
    configure(2'd2, 1'b1);
    src_gap_pct = 33;
    sink_stall_pct = 70;
    repeat (2) send_random_entry();
    rl = 16'(block_size_now() - blk_off + 4);
    send_byte(8'h21);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(rl[7:0]);
    send_byte(rl[15:8]);
    send_byte(8'd1);
    repeat (16) send_byte(8'($urandom_range(255)));
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL directory_entry_parser");
    $finish;
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_special_names();
    test_block_size_change();
    test_random_traffic(40, 2'd3, 1'b1, 33, 70);
    test_random_traffic(40, 2'd2, 1'b0, 70, 33);
    test_random_traffic(40, 2'd1, 1'b1, 0, 0);
    test_corrupt_freeze();
    settle_results();
    $display("covered %0d data bytes and %0d results over 1k to 4k blocks,", bytes_sent,
             results_checked);
    $display("dot names, unused entries, a block overrun and a freeze after a corrupt record");
    if (mismatches == 0) $display("PASS directory_entry_parser");
    else $display("FAIL directory_entry_parser");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/dep_pkg.sv
sv/directory_entry_parser.sv
sim/tb_top.sv
